### src/dtlv_pkg.sv
`timescale 1ns / 1ps
package dtlv_pkg;

	localparam int unsigned LEN_BYTES_MAX = 4;

	localparam int LEN_CNT_W = 4;
	localparam int LEN_W     = 32;

	// parse phase codes
	localparam logic [2:0] PH_TAG      = 3'd0;
	localparam logic [2:0] PH_LEN      = 3'd1;
	localparam logic [2:0] PH_LLEN     = 3'd2;
	localparam logic [2:0] PH_VAL      = 3'd3;
	localparam logic [2:0] PH_ERR_ZLL  = 3'd4;
	localparam logic [2:0] PH_ERR_LONG = 3'd5;
	localparam logic [2:0] PH_ERR_TRNC = 3'd6;
	localparam logic [2:0] PH_UNUSED   = 3'd7;
	localparam logic [2:0] PH_ERR_BASE = 3'd3;

	// byte kinds
	localparam logic [1:0] KIND_TAG = 2'd0;
	localparam logic [1:0] KIND_LEN = 2'd1;
	localparam logic [1:0] KIND_VAL = 2'd2;
	localparam logic [1:0] KIND_ERR = 2'd3;

	// error codes
	localparam logic [1:0] ERR_NONE  = 2'd0;
	localparam logic [1:0] ERR_ZLL   = 2'd1;
	localparam logic [1:0] ERR_LONG  = 2'd2;
	localparam logic [1:0] ERR_TRUNC = 2'd3;

	localparam logic [7:0] LONG_FORM_BIT = 8'h80;
	localparam logic [7:0] LEN_MASK      = 8'h7F;

	typedef struct packed {
		logic [1:0]       byte_kind;
		logic [7:0]       tag_value;
		logic [LEN_W-1:0] value_length;
		logic [7:0]       byte_out;
		logic             element_end;
		logic [1:0]       error_code;
	} res_t;

endpackage

### src/dtlv_if.sv
`timescale 1ns / 1ps
interface dtlv_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface dtlv_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  byte_kind;
	logic [7:0]  tag_value;
	logic [31:0] value_length;
	logic [7:0]  byte_out;
	logic        element_end;
	logic [1:0]  error_code;

	modport source (output valid, output byte_kind, output tag_value, output value_length,
		output byte_out, output element_end, output error_code, input ready);
	modport sink (input valid, input byte_kind, input tag_value, input value_length,
		input byte_out, input element_end, input error_code, output ready);
endinterface

### src/dtlv_decode.sv
`timescale 1ns / 1ps
module dtlv_decode (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          accept,
	input  logic [7:0]    data_byte,
	input  logic          last_byte,
	output dtlv_pkg::res_t res
);
	import dtlv_pkg::*;

	logic [2:0]           phase_q, phase_d;
	logic [7:0]           tag_q, tag_d;
	logic [LEN_W-1:0]     acc_q, acc_d;
	logic [LEN_CNT_W-1:0] lbl_q, lbl_d;
	logic [LEN_W-1:0]     vbl_q, vbl_d;

	logic [2:0] nxt;
	logic [1:0] kind;
	logic [1:0] code;
	logic       elem_end;
	logic       in_err;
	logic [6:0] n_len;

	assign n_len = 7'(data_byte & LEN_MASK);

	always_comb begin
		nxt      = PH_TAG;
		kind     = KIND_TAG;
		code     = ERR_NONE;
		elem_end = 1'b0;
		in_err   = 1'b0;
		tag_d    = tag_q;
		acc_d    = acc_q;
		lbl_d    = lbl_q;
		vbl_d    = vbl_q;

		unique case (phase_q)
			PH_LEN: begin
				kind = KIND_LEN;
				if ((data_byte & LONG_FORM_BIT) == 8'h00) begin
					acc_d = LEN_W'(data_byte);
					if (data_byte == 8'h00) begin
						elem_end = 1'b1;
					end else begin
						vbl_d = LEN_W'(data_byte);
						nxt   = PH_VAL;
					end
				end else if (n_len == 7'd0) begin
					code = ERR_ZLL;
				end else if (32'(n_len) > LEN_BYTES_MAX) begin
					code = ERR_LONG;
				end else begin
					lbl_d = n_len[LEN_CNT_W-1:0];
					acc_d = '0;
					nxt   = PH_LLEN;
				end
			end
			PH_LLEN: begin
				kind  = KIND_LEN;
				acc_d = {acc_q[LEN_W-9:0], data_byte};
				lbl_d = lbl_q - LEN_CNT_W'(1);
				if (lbl_d == '0) begin
					if (acc_d == '0) begin
						elem_end = 1'b1;
					end else begin
						vbl_d = acc_d;
						nxt   = PH_VAL;
					end
				end else begin
					nxt = PH_LLEN;
				end
			end
			PH_VAL: begin
				kind  = KIND_VAL;
				vbl_d = vbl_q - LEN_W'(1);
				if (vbl_d == '0) begin
					elem_end = 1'b1;
				end else begin
					nxt = PH_VAL;
				end
			end
			PH_ERR_ZLL, PH_ERR_LONG, PH_ERR_TRNC: begin
				in_err = 1'b1;
				kind   = KIND_ERR;
				code   = 2'(phase_q - PH_ERR_BASE);
				nxt    = phase_q;
			end
			default: begin
				// tag byte; the unused phase code behaves the same
				tag_d = data_byte;
				acc_d = '0;
				lbl_d = '0;
				vbl_d = '0;
				nxt   = PH_LEN;
			end
		endcase

		if (code != ERR_NONE && !in_err) begin
			kind     = KIND_ERR;
			elem_end = 1'b0;
			nxt      = PH_ERR_BASE + 3'(code);
		end

		// end of buffer: anything left open is truncated
		if (last_byte) begin
			if (code == ERR_NONE && nxt != PH_TAG) begin
				code     = ERR_TRUNC;
				kind     = KIND_ERR;
				elem_end = 1'b0;
			end
			nxt   = PH_TAG;
			lbl_d = '0;
			vbl_d = '0;
		end

		phase_d = nxt;
	end

	assign res.byte_kind    = kind;
	assign res.tag_value    = tag_d;
	assign res.value_length = acc_d;
	assign res.byte_out     = data_byte;
	assign res.element_end  = elem_end;
	assign res.error_code   = code;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_TAG;
			tag_q   <= '0;
			acc_q   <= '0;
			lbl_q   <= '0;
			vbl_q   <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			tag_q   <= tag_d;
			acc_q   <= acc_d;
			lbl_q   <= lbl_d;
			vbl_q   <= vbl_d;
		end
	end

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && last_byte |=> phase_q == PH_TAG && lbl_q == '0 && vbl_q == '0)
		else $error("buffer end did not return to tag phase");

	a_val_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_VAL |-> vbl_q != '0)
		else $error("value phase with no bytes left");

	a_llen_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_LLEN |-> lbl_q != '0 && 32'(lbl_q) <= LEN_BYTES_MAX)
		else $error("length byte count out of range");

	a_no_unused: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != PH_UNUSED)
		else $error("unused phase reached");

endmodule

### src/der_tlv_stream_parser_core.sv
`timescale 1ns / 1ps
// A result is registered into the output register, or into the skid entry while the output register is full.
// Throughput: one byte per cycle while the skid entry is empty; the phase and counter registers close
// their update loop within that cycle.
// A result register plus one skid entry keeps input ready while one result waits.
// Reset (arst_n low) clears the phase, tag, length and counters, empties the output.
module der_tlv_stream_parser_core (
	input  logic clk,
	input  logic arst_n,
	dtlv_in_if.sink    rx,
	dtlv_out_if.source tx
);
	import dtlv_pkg::*;

	res_t res_new;
	res_t out_q;
	res_t skid_q;
	logic out_v_q;
	logic skid_v_q;
	logic fire_in;
	logic fire_out;

	assign rx.ready = !skid_v_q;
	assign fire_in  = rx.valid && rx.ready;
	assign fire_out = out_v_q && tx.ready;

	dtlv_decode u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (fire_in),
		.data_byte (rx.data_byte),
		.last_byte (rx.last_byte),
		.res       (res_new)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (fire_out) begin
			if (skid_v_q) begin
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= fire_in;
			end
		end else if (fire_in) begin
			if (out_v_q) begin
				skid_v_q <= 1'b1;
			end else begin
				out_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire_out) begin
			if (skid_v_q) begin
				out_q <= skid_q;
			end else if (fire_in) begin
				out_q <= res_new;
			end
		end else if (fire_in) begin
			if (out_v_q) begin
				skid_q <= res_new;
			end else begin
				out_q <= res_new;
			end
		end
	end

	assign tx.valid        = out_v_q;
	assign tx.byte_kind    = out_q.byte_kind;
	assign tx.tag_value    = out_q.tag_value;
	assign tx.value_length = out_q.value_length;
	assign tx.byte_out     = out_q.byte_out;
	assign tx.element_end  = out_q.element_end;
	assign tx.error_code   = out_q.error_code;

	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid entry held with empty output register");

	a_accept_shows: assert property (@(posedge clk) disable iff (!arst_n)
		fire_in && !out_v_q |=> out_v_q)
		else $error("accepted item not presented");

	a_kind_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q |-> (out_q.error_code != ERR_NONE) == (out_q.byte_kind == KIND_ERR))
		else $error("error kind and code disagree");

endmodule
